// ===== sv/byte_to_radix_text_dump_defines.svh =====
// Assertion macros for the files that check their own logic; only the top level uses them.
`ifndef BYTE_TO_RADIX_TEXT_DUMP_DEFINES_SVH
`define BYTE_TO_RADIX_TEXT_DUMP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define B2R_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define B2R_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/b2r_pkg.sv =====
// ----------------------------------------------------------------------------
// b2r_pkg
// Types, codes and character functions of the byte to radix text encoder.
// ----------------------------------------------------------------------------
package b2r_pkg;

    localparam int SEPARATOR_MAX = 4;
    localparam int SEP_IDX_W     = $clog2(SEPARATOR_MAX);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    // Radix codes.
    localparam logic [1:0] RADIX_HEX = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_RADIX_MODE  = 3'd0;
    localparam logic [2:0] REG_UPPER_CASE  = 3'd1;
    localparam logic [2:0] REG_SPLIT_EVERY = 3'd2;
    localparam logic [2:0] REG_SEP_LENGTH  = 3'd3;
    localparam logic [2:0] REG_SEP_CHARS   = 3'd4;
    localparam logic [2:0] REG_LEN_LIMIT   = 3'd5;

    typedef struct packed {
        logic [1:0]  radix_mode;
        logic        upper_case;
        logic [7:0]  split_every;
        logic [2:0]  separator_length;
        logic [31:0] separator_chars;
        logic [15:0] length_limit;
    } t_cfg;

    // One classified item waiting for the back end.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start;
        logic [3:0] ndig;
    } t_item;

    function automatic logic [3:0] digit_count(input logic [1:0] radix);
        logic [3:0] n;
        case (radix)
            RADIX_HEX: n = 4'd2;
            RADIX_OCT: n = 4'd3;
            RADIX_BIN: n = 4'd8;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    // ASCII character of digit idx of a byte, most significant digit first.
    function automatic logic [7:0] digit_char(input logic [1:0] radix, input logic upper,
                                              input logic [7:0] b, input logic [2:0] idx);
        logic [3:0] v;
        case (radix)
            RADIX_HEX: v = (idx == 3'd0) ? b[7:4] : b[3:0];
            RADIX_OCT: begin
                case (idx)
                    3'd0:    v = {2'b00, b[7:6]};
                    3'd1:    v = {1'b0, b[5:3]};
                    default: v = {1'b0, b[2:0]};
                endcase
            end
            RADIX_BIN: v = {3'b000, b[3'd7 - idx]};
            default:   v = 4'd0;
        endcase
        if (v < 4'd10) begin
            return 8'h30 + {4'h0, v};
        end
        return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    endfunction

endpackage

// ===== sv/b2r_cfg.sv =====
// ----------------------------------------------------------------------------
// b2r_cfg
// Configuration register bank with its write channel.
// ----------------------------------------------------------------------------
module b2r_cfg
    import b2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix_mode       <= RADIX_HEX;
            r_cfg.upper_case       <= 1'b0;
            r_cfg.split_every      <= 8'd0;
            r_cfg.separator_length <= 3'd0;
            r_cfg.separator_chars  <= 32'd0;
            r_cfg.length_limit     <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RADIX_MODE:  r_cfg.radix_mode       <= i_cfg_data[1:0];
                REG_UPPER_CASE:  r_cfg.upper_case       <= i_cfg_data[0];
                REG_SPLIT_EVERY: r_cfg.split_every      <= i_cfg_data[7:0];
                REG_SEP_LENGTH:  r_cfg.separator_length <= i_cfg_data[2:0];
                REG_SEP_CHARS:   r_cfg.separator_chars  <= i_cfg_data;
                REG_LEN_LIMIT:   r_cfg.length_limit     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/b2r_front.sv =====
// ----------------------------------------------------------------------------
// b2r_front
// Accepts input items, works out their digit count and queues them.
// ----------------------------------------------------------------------------
module b2r_front
    import b2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_start,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic              push;
    logic              pop;
    t_item             new_item;

    assign o_ready   = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    always_comb begin
        new_item.data_byte = i_data_byte;
        new_item.start     = i_start;
        new_item.ndig      = digit_count(i_cfg.radix_mode);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QUEUE_AW + 1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

// ===== sv/b2r_back.sv =====
// ----------------------------------------------------------------------------
// b2r_back
// Character sequencer: digits, separators, counters and the output register.
// ----------------------------------------------------------------------------
module b2r_back
    import b2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char,
    output logic        o_last,
    output logic [16:0] o_count,
    output logic        o_busy
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIGIT, ST_SEP} t_state;

    localparam logic [2:0] SEP_MAX_L = 3'(SEPARATOR_MAX);

    t_state               r_state, n_state;
    logic [7:0]           r_byte, n_byte;
    logic [3:0]           r_ndig, n_ndig;
    logic [2:0]           r_dig_idx, n_dig_idx;
    logic [SEP_IDX_W-1:0] r_sep_idx, n_sep_idx;
    logic [16:0]          r_cnt, n_cnt;
    logic [7:0]           r_dss, n_dss;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;
    logic [16:0]          r_out_cnt, n_out_cnt;

    logic        adv;
    logic [16:0] lim;
    logic [16:0] cnt_n;
    logic [16:0] cnt_base;
    logic [7:0]  dss_inc;
    logic [2:0]  len_eff;
    logic        trig;
    logic        sep_go;
    logic        sep_end;
    logic        last_digit;

    assign adv        = !r_out_valid || i_ready;
    assign lim        = {1'b0, i_cfg.length_limit};
    assign cnt_n      = r_cnt + 17'd1;
    assign dss_inc    = r_dss + 8'd1;
    assign len_eff    = (i_cfg.separator_length > SEP_MAX_L) ? SEP_MAX_L
                                                             : i_cfg.separator_length;
    // The digit count may already stand above a newly written split value.
    assign trig       = (i_cfg.split_every != 8'd0) && !(dss_inc < i_cfg.split_every);
    // Once one separator character is blocked by the limit all later ones are too.
    assign sep_go     = trig && (len_eff != 3'd0) && (cnt_n < lim);
    assign sep_end    = (3'(r_sep_idx) == len_eff - 3'd1) || !(cnt_n < lim);
    assign last_digit = ({1'b0, r_dig_idx} == r_ndig - 4'd1);
    assign cnt_base   = i_q_item.start ? 17'd0 : r_cnt;

    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_ndig      = r_ndig;
        n_dig_idx   = r_dig_idx;
        n_sep_idx   = r_sep_idx;
        n_cnt       = r_cnt;
        n_dss       = r_dss;
        n_out_valid = adv ? 1'b0 : r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_cnt   = r_out_cnt;
        o_q_pop     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_cnt     = cnt_base;
                    n_dss     = i_q_item.start ? 8'd0 : r_dss;
                    n_byte    = i_q_item.data_byte;
                    n_ndig    = i_q_item.ndig;
                    n_dig_idx = 3'd0;
                    n_sep_idx = '0;
                    // Unused radix or a reached limit: the item leaves no character.
                    if (i_q_item.ndig != 4'd0 && cnt_base < lim) begin
                        n_state = ST_DIGIT;
                    end
                end
            end
            ST_DIGIT: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(i_cfg.radix_mode, i_cfg.upper_case,
                                             r_byte, r_dig_idx);
                    n_out_cnt   = cnt_n;
                    n_out_last  = 1'b0;
                    n_cnt       = cnt_n;
                    if (i_cfg.split_every != 8'd0) begin
                        n_dss = trig ? 8'd0 : dss_inc;
                    end
                    if (sep_go) begin
                        n_state   = ST_SEP;
                        n_sep_idx = '0;
                    end else if (last_digit) begin
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_dig_idx = r_dig_idx + 3'd1;
                    end
                end
            end
            ST_SEP: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_char  = i_cfg.separator_chars[8*r_sep_idx +: 8];
                    n_out_cnt   = cnt_n;
                    n_out_last  = 1'b0;
                    n_cnt       = cnt_n;
                    if (sep_end) begin
                        if (last_digit) begin
                            n_out_last = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            n_dig_idx = r_dig_idx + 3'd1;
                            n_state   = ST_DIGIT;
                        end
                    end else begin
                        n_sep_idx = r_sep_idx + SEP_IDX_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_ndig     <= n_ndig;
        r_dig_idx  <= n_dig_idx;
        r_sep_idx  <= n_sep_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_cnt  <= n_out_cnt;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 17'd0;
            r_dss       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dss       <= n_dss;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;
    assign o_count = r_out_cnt;
    assign o_busy  = (r_state != ST_IDLE);

endmodule

// ===== sv/byte_to_radix_text_dump.sv =====
// An accepted item is written into the queue and then loaded from it into the back end
// registers; its first character is registered into the output register once the output can advance.
// Each item gives 2, 3 or 8 digit characters plus any separators, and the back end loads a
// new item only from its idle state. An item that gives no characters is still popped by the back end.
// Reset is synchronous and active low; it restores the register defaults and clears the
// counters and the queue.
// ----------------------------------------------------------------------------
// byte_to_radix_text_dump
// Renders bytes as hex, octal or binary ASCII text with optional separators.
// ----------------------------------------------------------------------------
`include "byte_to_radix_text_dump_defines.svh"

module byte_to_radix_text_dump
    import b2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic        i_s_axis_tuser,  // [0] start_of_buffer
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [7:0] text_char, [24:8] chars_so_far, rest 0
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg        cfg;
    logic        q_valid;
    t_item       q_item;
    logic        q_pop;
    logic [7:0]  out_char;
    logic [16:0] out_count;
    logic        back_busy;

    b2r_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    b2r_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data_byte (i_s_axis_tdata),
        .i_start     (i_s_axis_tuser),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    b2r_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_char    (out_char),
        .o_last    (o_m_axis_tlast),
        .o_count   (out_count),
        .o_busy    (back_busy)
    );

    assign o_m_axis_tdata = {7'd0, out_count, out_char};

    // Every character delivered has been counted.
    `B2R_ASSERT(a_count_nonzero, o_m_axis_tvalid |-> (out_count != 17'd0), "zero character count")
    // A character that is not the last of its item means the sequencer still owns that item.
    `B2R_ASSERT(a_busy_mid_item, (o_m_axis_tvalid && !o_m_axis_tlast) |-> back_busy, "item left unfinished")
    // Nothing is offered in the cycle after reset.
    `B2R_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

// ===== bench/b2r_text_checker.sv =====
// ----------------------------------------------------------------------------
// b2r_text_checker
// Watches the byte, text and register channels of the radix text encoder,
// predicts the characters that each accepted byte gives and compares every
// accepted character, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module b2r_text_checker
    import b2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic        i_in_start,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHARS_PER_BYTE = 40;
    localparam int EXP_DEPTH          = 1024;

    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_ONE  = "1";
    localparam logic [7:0] CH_A_UP = "A";
    localparam logic [7:0] CH_A_LO = "a";

    typedef struct packed {
        logic [7:0]  text_char;
        logic        run_last;
        logic [16:0] chars_so_far;
    } t_text_char;

    t_cfg        regs;
    logic [16:0] char_count;
    logic [7:0]  digits_since_split;
    t_text_char  text_exp_mem[EXP_DEPTH];
    int          exp_rd;
    int          exp_wr;
    int          exp_level;
    t_text_char  byte_chars[MAX_CHARS_PER_BYTE];
    int          byte_nchars;
    int          error_count;

    function automatic logic [7:0] digit_glyph(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return CH_ZERO + {4'h0, v};
        end
        return (upper ? CH_A_UP : CH_A_LO) + {4'h0, v} - 8'd10;
    endfunction

    task automatic add_char(input logic [7:0] ch);
        char_count = char_count + 17'd1;
        byte_chars[byte_nchars] = '{text_char: ch, run_last: 1'b0, chars_so_far: char_count};
        byte_nchars++;
    endtask

    // A digit may close a group; the separator that follows is cut off at the limit.
    task automatic add_digit(input logic [7:0] ch);
        int sep_len;
        add_char(ch);
        if (regs.split_every == 8'd0) begin
            return;
        end
        digits_since_split = digits_since_split + 8'd1;
        if (digits_since_split < regs.split_every) begin
            return;
        end
        digits_since_split = 8'd0;
        sep_len = int'(regs.separator_length);
        if (sep_len > SEPARATOR_MAX) begin
            sep_len = SEPARATOR_MAX;
        end
        for (int k = 0; k < sep_len; k++) begin
            if (char_count < {1'b0, regs.length_limit}) begin
                add_char((k < 4) ? regs.separator_chars[8*k +: 8] : 8'h00);
            end
        end
    endtask

    task automatic render_byte(input logic [7:0] b, input logic start);
        if (start) begin
            char_count         = 17'd0;
            digits_since_split = 8'd0;
        end
        if (char_count >= {1'b0, regs.length_limit}) begin
            return;
        end
        byte_nchars = 0;
        case (regs.radix_mode)
            RADIX_HEX: begin
                add_digit(digit_glyph(b[7:4], regs.upper_case));
                add_digit(digit_glyph(b[3:0], regs.upper_case));
            end
            RADIX_OCT: begin
                add_digit(digit_glyph({2'b00, b[7:6]}, 1'b0));
                add_digit(digit_glyph({1'b0, b[5:3]}, 1'b0));
                add_digit(digit_glyph({1'b0, b[2:0]}, 1'b0));
            end
            RADIX_BIN: begin
                for (int k = 7; k >= 0; k--) begin
                    add_digit(b[k] ? CH_ONE : CH_ZERO);
                end
            end
            default: begin
            end
        endcase
        if (byte_nchars > 0) begin
            byte_chars[byte_nchars - 1].run_last = 1'b1;
        end
        for (int k = 0; k < byte_nchars; k++) begin
            text_exp_mem[exp_wr] = byte_chars[k];
            exp_wr = (exp_wr + 1) % EXP_DEPTH;
            exp_level++;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        error_count++;
    endtask

    task automatic check_char();
        t_text_char want;
        if (exp_level == 0) begin
            $display("%0t: character with none expected: expected nothing, actual %h last %b",
                     $time, i_out_data, i_out_last);
            error_count++;
            return;
        end
        want = text_exp_mem[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_DEPTH;
        exp_level--;
        if (i_out_data[7:0] !== want.text_char) begin
            note_mismatch("text_char", 32'(want.text_char), 32'(i_out_data[7:0]));
        end
        if (i_out_last !== want.run_last) begin
            note_mismatch("run_last", 32'(want.run_last), 32'(i_out_last));
        end
        if (i_out_data[24:8] !== want.chars_so_far) begin
            note_mismatch("chars_so_far", 32'(want.chars_so_far), 32'(i_out_data[24:8]));
        end
        if (i_out_data[31:25] !== 7'd0) begin
            note_mismatch("tdata padding", 32'd0, 32'(i_out_data[31:25]));
        end
    endtask

    initial begin
        error_count = 0;
        exp_rd      = 0;
        exp_wr      = 0;
        exp_level   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.radix_mode       = RADIX_HEX;
            regs.upper_case       = 1'b0;
            regs.split_every      = 8'd0;
            regs.separator_length = 3'd0;
            regs.separator_chars  = 32'd0;
            regs.length_limit     = 16'hFFFF;
            char_count            = 17'd0;
            digits_since_split    = 8'd0;
            exp_rd                = 0;
            exp_wr                = 0;
            exp_level             = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RADIX_MODE:  regs.radix_mode       = i_cfg_data[1:0];
                    REG_UPPER_CASE:  regs.upper_case       = i_cfg_data[0];
                    REG_SPLIT_EVERY: regs.split_every      = i_cfg_data[7:0];
                    REG_SEP_LENGTH:  regs.separator_length = i_cfg_data[2:0];
                    REG_SEP_CHARS:   regs.separator_chars  = i_cfg_data;
                    REG_LEN_LIMIT:   regs.length_limit     = i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                render_byte(i_in_data, i_in_start);
            end
            if (i_out_valid && i_out_ready) begin
                check_char();
            end
        end
        o_pending <= exp_level;
        o_errors  <= error_count;
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the radix text encoder with directed and random bytes under changing
// register settings and random stalls on both streams, and reports the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import b2r_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS  = 340;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          LONG_HOLD     = 400;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam logic [1:0]  RADIX_UNUSED  = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int          errors;
    int          pending;
    int unsigned cycle_cnt = 0;
    bit          tx_fast   = 1'b0;
    bit          rx_fast   = 1'b0;
    bit          hold_req  = 1'b0;

    byte_to_radix_text_dump DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    b2r_text_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_ready  (o_s_axis_tready),
        .i_in_data   (i_s_axis_tdata),
        .i_in_start  (i_s_axis_tuser),
        .i_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_out_data  (o_m_axis_tdata),
        .i_out_last  (o_m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // The valid is left high after acceptance so that a back-to-back item never
    // sees it lowered and raised within one step.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] radix, input logic upper,
                             input logic [7:0] split, input logic [2:0] sep_len,
                             input logic [31:0] sep_chars, input logic [15:0] limit);
        logic [2:0]  reg_index [6];
        logic [31:0] reg_value [6];
        reg_index = '{REG_RADIX_MODE, REG_UPPER_CASE, REG_SPLIT_EVERY,
                      REG_SEP_LENGTH, REG_SEP_CHARS, REG_LEN_LIMIT};
        reg_value = '{32'(radix), 32'(upper), 32'(split), 32'(sep_len), sep_chars, 32'(limit)};
        for (int k = 0; k < 6; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_index[k];
            i_cfg_data  <= reg_value[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every predicted character, then let bytes that give
    // no characters drain through the block.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : receiver
        int stall;
        bit hold_taken;
        hold_taken = 1'b0;
        i_m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = rx_fast ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
                while (!o_m_axis_tvalid) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [1:0]  radix;
        logic        upper;
        logic [7:0]  split;
        logic [2:0]  sep_len;
        logic [31:0] sep_chars;
        logic [15:0] limit;
        logic        start;
        int          n_items;
        int          left_in_buf;
        int          items_sent;
        int          phase;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        i_s_axis_tuser  <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_RADIX_MODE;
        i_cfg_data      <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Plain lower-case hex with no separators.
        configure(RADIX_HEX, 1'b0, 8'd0, 3'd0, 32'h0000_0000, 16'hFFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        settle();

        configure(RADIX_HEX, 1'b1, 8'd2, 3'd2, 32'h0000_3A20, 16'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC3, 1'b0);
        settle();

        configure(RADIX_OCT, 1'b0, 8'd3, 3'd1, 32'h0000_0020, 16'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h92, 1'b0);
        settle();

        // A separator after every binary digit, length above the maximum.
        configure(RADIX_BIN, 1'b0, 8'd1, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_byte(8'h80, 1'b1);
        settle();

        configure(RADIX_BIN, 1'b1, 8'd255, 3'd4, 32'h4433_2211, 16'hFFFF);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFE, 1'b0);
        settle();

        // The separator is cut at the limit, the started byte is completed, the next
        // byte is dropped and a new buffer starts counting again.
        configure(RADIX_HEX, 1'b0, 8'd2, 3'd4, 32'h2D2D_2D2D, 16'd7);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        settle();

        configure(RADIX_HEX, 1'b0, 8'd0, 3'd0, 32'h0000_0000, 16'd0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        settle();

        configure(RADIX_UNUSED, 1'b0, 8'd0, 3'd0, 32'h0000_0000, 16'hFFFF);
        send_byte(8'h69, 1'b1);
        send_byte(8'h96, 1'b0);
        settle();

        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            radix     = ($urandom_range(0, 9) == 0) ? RADIX_UNUSED : 2'($urandom_range(0, 2));
            upper     = 1'($urandom_range(0, 1));
            sep_len   = 3'($urandom_range(0, 7));
            sep_chars = $urandom;
            case ($urandom_range(0, 4))
                0:       split = 8'd0;
                1:       split = 8'd1;
                2:       split = 8'd255;
                3:       split = 8'($urandom_range(2, 12));
                default: split = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0:          limit = 16'd0;
                1, 2, 3:    limit = 16'($urandom_range(1, 80));
                4, 5:       limit = 16'($urandom_range(0, 65535));
                default:    limit = 16'hFFFF;
            endcase
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            // One phase stalls the text side for a long time while bytes keep coming.
            if (phase == 3) begin
                radix    = RADIX_BIN;
                limit    = 16'hFFFF;
                tx_fast  = 1'b1;
                hold_req = 1'b1;
            end
            configure(radix, upper, split, sep_len, sep_chars, limit);

            n_items     = (limit == 16'd0) ? 4 : $urandom_range(20, 40);
            left_in_buf = 0;
            for (int k = 0; k < n_items; k++) begin
                if (left_in_buf == 0) begin
                    left_in_buf = $urandom_range(1, 24);
                    start       = 1'b1;
                end else begin
                    start = 1'b0;
                end
                if ($urandom_range(0, 15) == 0) begin
                    start = ~start;
                end
                left_in_buf--;
                send_byte(8'($urandom_range(0, 255)), start);
            end
            if (limit != 16'd0) begin
                items_sent += n_items;
            end
            settle();
            phase++;
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
